>>> design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/spso_pkg.sv
package spso_pkg;
  localparam int MaxElements = 64;
  localparam int CoordWidth = 24;
  localparam int IdWidth = 16;
  localparam int ResultLimit = 63;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT_RD, S_SHIFT_CMP, S_WRITE, S_ROW_RD, S_ROW_CAP,
    S_J_RD, S_J_CAP, S_MUL, S_CMP, S_EMIT, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    M_DX, M_DY, M_DZ, M_RS
  } mstep_t;
endpackage

>>> design/sweep_prune_sphere_overlap.sv
// channel  dir  fields (tdata low bit up)
// s_axis   in   op[1:0] elem_id[17:2] pos_x pos_y pos_z radius row, tdata 120 bits
// m_axis   out  status[1:0] pair_valid[2] first_id[18:3] second_id[34:19], tlast = last
// a clear or undefined op is answered straight from idle; a load walks the store
// from the top, shifting each entry up until the compare stops, then writes; a sweep
// reads the row and then each partner in turn, all through one
// multiplier and one accumulator
// rst clears element count and control; the store holds no reset
// s_axis_tready is high only in idle; a result waits in the output register
// until m_axis_tready takes it, and the scan stalls meanwhile
`include "assert_macros.svh"
module sweep_prune_sphere_overlap #(
  parameter int MaxElements = spso_pkg::MaxElements,
  parameter int CoordWidth = spso_pkg::CoordWidth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,   // op, elem_id, pos_x, pos_y, pos_z, radius, row
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // status, pair_valid, first_id, second_id
  output logic         m_axis_tlast
);
  localparam int AW = $clog2(MaxElements);
  localparam int CW = $clog2(MaxElements + 1);
  localparam int W = CoordWidth;
  localparam int EW = spso_pkg::IdWidth + 4 * W - 1;

  spso_pkg::state_t state, state_next;

  // input field extraction
  logic [1:0]  in_op;
  logic [15:0] in_id;
  logic signed [W-1:0] in_x, in_y, in_z;
  logic [W-2:0] in_r;
  logic [5:0] in_row;
  assign in_op  = s_axis_tdata[1:0];
  assign in_id  = s_axis_tdata[17:2];
  assign in_x   = s_axis_tdata[18 +: W];
  assign in_y   = s_axis_tdata[42 +: W];
  assign in_z   = s_axis_tdata[66 +: W];
  assign in_r   = s_axis_tdata[90 +: W-1];
  assign in_row = s_axis_tdata[113 +: 6];

  // element store: one ram holding id, x, y, z, r
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  spso_ram #(.Width(EW), .Depth(MaxElements)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  logic [15:0] rd_id;
  logic signed [W-1:0] rd_x, rd_y, rd_z;
  logic [W-2:0] rd_r;
  assign rd_id = rdata[15:0];
  assign rd_x  = rdata[16 +: W];
  assign rd_y  = rdata[16+W +: W];
  assign rd_z  = rdata[16+2*W +: W];
  assign rd_r  = rdata[16+3*W +: W-1];

  // registers
  logic [CW-1:0] count;
  logic [CW-1:0] pos;       // load insert position / sweep partner index
  logic [EW-1:0] item;      // loaded item or row element
  logic [5:0]    npairs;
  logic [15:0]   p_id;
  logic signed [W-1:0] p_x, p_y, p_z;
  logic [W-2:0]  p_r;
  logic [2*W+3:0] d2;
  logic [2:0]     mstep;
  logic           stop;

  logic [15:0] it_id;
  logic signed [W-1:0] it_x, it_y, it_z;
  logic [W-2:0] it_r;
  assign it_id = item[15:0];
  assign it_x  = item[16 +: W];
  assign it_y  = item[16+W +: W];
  assign it_z  = item[16+2*W +: W];
  assign it_r  = item[16+3*W +: W-1];

  // left-edge keys and the row's right edge, two bits wider than a coordinate
  logic signed [W+1:0] key_new, key_rd, right_row, key_p;
  assign key_new   = (W+2)'(it_x) - (W+2)'(signed'({1'b0, it_r}));
  assign key_rd    = (W+2)'(rd_x) - (W+2)'(signed'({1'b0, rd_r}));
  assign right_row = (W+2)'(it_x) + (W+2)'(signed'({1'b0, it_r}));
  assign key_p     = (W+2)'(p_x) - (W+2)'(signed'({1'b0, p_r}));

  // mac operand select
  logic [W:0] mac_a;
  logic mac_clr, mac_en;
  logic [2*W+3:0] acc;
  always_comb begin
    logic signed [W:0] d;
    d = '0;
    case (mstep)
      spso_pkg::M_DX: d = (W+1)'(it_x) - (W+1)'(p_x);
      spso_pkg::M_DY: d = (W+1)'(it_y) - (W+1)'(p_y);
      spso_pkg::M_DZ: d = (W+1)'(it_z) - (W+1)'(p_z);
      default: d = signed'({2'b00, it_r}) + signed'({2'b00, p_r});
    endcase
    mac_a = d[W] ? (W+1)'(-d) : d;
  end
  spso_mac #(.CoordWidth(W)) u_mac (
    .clk(clk), .clr(mac_clr), .en(mac_en), .a(mac_a), .acc(acc));

  // output register
  logic [1:0]  o_status;
  logic        o_pv, o_last;
  logic [15:0] o_first, o_second;
  logic        o_load;
  logic [1:0]  n_status;
  logic        n_pv, n_last;
  logic [15:0] n_first, n_second;

  assign s_axis_tready = (state == spso_pkg::S_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata  = {5'd0, o_second, o_first, o_pv, o_status};
  assign m_axis_tlast  = o_last;

  logic [CW-1:0] pos_next, count_next;
  logic [EW-1:0] item_next;
  logic [5:0] npairs_next;
  logic [2:0] mstep_next;
  logic stop_next, p_load, d2_load;

  always_comb begin
    state_next = state;
    pos_next = pos; count_next = count; item_next = item;
    npairs_next = npairs; mstep_next = mstep; stop_next = stop;
    we = 1'b0; waddr = pos[AW-1:0]; wdata = item; raddr = pos[AW-1:0];
    mac_clr = 1'b0; mac_en = 1'b0; p_load = 1'b0; d2_load = 1'b0;
    o_load = 1'b0;
    n_status = spso_pkg::ST_OK; n_pv = 1'b0; n_last = 1'b1;
    n_first = '0; n_second = '0;
    case (state)
      spso_pkg::S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          item_next = {in_r, in_z, in_y, in_x, in_id};
          case (in_op)
            spso_pkg::OP_CLEAR: begin
              count_next = '0; o_load = 1'b1;
            end
            spso_pkg::OP_LOAD: begin
              if (count >= CW'(MaxElements)) begin
                n_status = spso_pkg::ST_FULL; o_load = 1'b1;
              end else begin
                pos_next = count;
                state_next = (count == '0) ? spso_pkg::S_WRITE : spso_pkg::S_SHIFT_RD;
              end
            end
            spso_pkg::OP_SWEEP: begin
              if (32'(in_row) >= 32'(count)) begin
                n_status = spso_pkg::ST_RANGE; o_load = 1'b1;
              end else begin
                pos_next = CW'(in_row); npairs_next = '0;
                state_next = spso_pkg::S_ROW_RD;
              end
            end
            default: o_load = 1'b1;
          endcase
        end
      end
      spso_pkg::S_SHIFT_RD: begin
        raddr = AW'(pos - 1'b1);
        state_next = spso_pkg::S_SHIFT_CMP;
      end
      spso_pkg::S_SHIFT_CMP: begin
        raddr = AW'(pos - 1'b1);
        if (key_rd > key_new) begin
          we = 1'b1; wdata = rdata;
          pos_next = pos - 1'b1;
          state_next = (pos == CW'(1)) ? spso_pkg::S_WRITE : spso_pkg::S_SHIFT_RD;
        end else begin
          state_next = spso_pkg::S_WRITE;
        end
      end
      spso_pkg::S_WRITE: begin
        we = 1'b1; count_next = count + 1'b1; o_load = 1'b1;
        state_next = spso_pkg::S_OUT;
      end
      spso_pkg::S_ROW_RD: state_next = spso_pkg::S_ROW_CAP;
      spso_pkg::S_ROW_CAP: begin
        item_next = rdata; pos_next = pos + 1'b1; stop_next = 1'b0;
        state_next = spso_pkg::S_CMP;
      end
      spso_pkg::S_J_RD: state_next = spso_pkg::S_J_CAP;
      spso_pkg::S_J_CAP: begin
        p_load = 1'b1; mac_clr = 1'b1; mstep_next = spso_pkg::M_DX;
        state_next = spso_pkg::S_MUL;
      end
      spso_pkg::S_MUL: begin
        // steps 0..2 feed squares, step 3 feeds radius sum; each square reaches acc through the sq register
        mac_en = (mstep != 3'd0);
        mstep_next = mstep + 1'b1;
        if (mstep == 3'd4) begin
          d2_load = 1'b1;
          state_next = spso_pkg::S_EMIT;
        end
      end
      spso_pkg::S_EMIT: begin
        // acc holds rs^2 + d2 now; overlap when d2 < rs^2
        stop_next = right_row < key_p;
        if (acc - d2 > d2 && !m_axis_tvalid) begin
          n_pv = 1'b1; n_first = it_id; n_second = p_id; n_last = 1'b0;
          o_load = 1'b1; npairs_next = npairs + 1'b1;
          pos_next = pos + 1'b1;
          state_next = spso_pkg::S_CMP;
        end else if (!(acc - d2 > d2)) begin
          pos_next = pos + 1'b1;
          state_next = spso_pkg::S_CMP;
        end
      end
      spso_pkg::S_CMP: begin
        if (!m_axis_tvalid) begin
          if (stop || pos >= count || npairs == 6'(spso_pkg::ResultLimit)) begin
            o_load = 1'b1;
            if (npairs == '0) begin
              n_first = it_id;
              state_next = spso_pkg::S_OUT;
            end else begin
              n_pv = 1'b1; n_first = o_first; n_second = o_second;
              o_load = 1'b0;
              state_next = spso_pkg::S_OUT;
            end
          end else begin
            state_next = spso_pkg::S_J_RD;
          end
        end
      end
      spso_pkg::S_OUT: begin
        if (!m_axis_tvalid) state_next = spso_pkg::S_IDLE;
      end
      default: state_next = spso_pkg::S_IDLE;
    endcase
  end

  // pairs are held back one step so the final one can carry last
  logic held;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spso_pkg::S_IDLE;
      count <= '0;
      m_axis_tvalid <= 1'b0;
      held <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (o_load && n_pv && !n_last) begin
        if (held) m_axis_tvalid <= 1'b1;
        held <= 1'b1;
      end else if (state == spso_pkg::S_CMP && state_next == spso_pkg::S_OUT && held) begin
        m_axis_tvalid <= 1'b1;
        held <= 1'b0;
      end else if (o_load) begin
        m_axis_tvalid <= 1'b1;
      end
    end
  end

  // held pair register, moved to output when the next pair appears or the sweep ends
  logic [15:0] h_first, h_second;
  always_ff @(posedge clk) begin
    pos <= pos_next; item <= item_next; npairs <= npairs_next;
    mstep <= mstep_next; stop <= stop_next;
    if (p_load) begin
      p_id <= rd_id; p_x <= rd_x; p_y <= rd_y; p_z <= rd_z; p_r <= rd_r;
    end
    if (d2_load) d2 <= acc;
    if (o_load && n_pv && !n_last) begin
      if (held) begin
        o_status <= spso_pkg::ST_OK; o_pv <= 1'b1; o_last <= 1'b0;
        o_first <= h_first; o_second <= h_second;
      end
      h_first <= n_first; h_second <= n_second;
    end else if (state == spso_pkg::S_CMP && state_next == spso_pkg::S_OUT && held) begin
      o_status <= spso_pkg::ST_OK; o_pv <= 1'b1; o_last <= 1'b1;
      o_first <= h_first; o_second <= h_second;
    end else if (o_load) begin
      o_status <= n_status; o_pv <= n_pv; o_last <= n_last;
      o_first <= n_first; o_second <= n_second;
    end
  end

  `ASSERT_IMPL(a_ready_idle, s_axis_tready, state == spso_pkg::S_IDLE,
    "ready outside idle")
  `ASSERT_IMPL(a_count_max, 1'b1, count <= CW'(MaxElements), "count overflow")
  `ASSERT_IMPL(a_pair_first, m_axis_tvalid && m_axis_tdata[2],
    m_axis_tdata[1:0] == spso_pkg::ST_OK, "pair with bad status")
  `ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "ready right after accept")
endmodule

>>> design/spso_ram.sv
module spso_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/spso_mac.sv
// shared square-and-accumulate unit: sq <= a*a registered, acc <= acc + sq, or clear
module spso_mac #(
  parameter int CoordWidth = spso_pkg::CoordWidth
) (
  input  logic                      clk,
  input  logic                      clr,
  input  logic                      en,
  input  logic [CoordWidth:0]       a,
  output logic [2*CoordWidth+3:0]   acc
);
  logic [2*CoordWidth+1:0] sq;

  always_ff @(posedge clk) begin
    sq <= a * a;
    if (clr) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc + {2'b00, sq};
    end
  end
endmodule
